// ===== rtl/prm_pkg.sv =====
// Package for the windowed pulse rate meter: widths, ring depth, codes,
// the ring entry and divider request types, and ring position helpers.
// No dependencies.
package prm_pkg;

  localparam int RING_DEPTH = 6;
  localparam int POS_W      = $clog2(RING_DEPTH);

  localparam int OP_W      = 2;
  localparam int COUNT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int RATE_W    = 36;
  localparam int NUM_RATES = 4;
  localparam int SCALE_W   = 20;
  localparam int ENTRY_W   = COUNT_W + TIME_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  // milli-pulses per second from pulses per millisecond
  localparam logic [SCALE_W-1:0]  MILLI_SCALE  = 20'd1000000;

  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RATE_INSTANT    = 2'd0,
    RATE_ONE        = 2'd1,
    RATE_FIVE       = 2'd2,
    RATE_TWENTYFIVE = 2'd3
  } rate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SNAP,
    S_RD_NEW,
    S_RD_OLD,
    S_PREP,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [RATE_W-1:0]  dividend;
    logic [TIME_W-1:0]  divisor;
  } div_req_t;

  function automatic pos_t next_pos(input pos_t p);
    if (p == pos_t'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic pos_t prev_pos(input pos_t p);
    if (p == '0) begin
      return pos_t'(RING_DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

endpackage

// ===== rtl/prm_if.sv =====
// Channel interfaces of the pulse rate meter: the item channel and the
// result channel, each with valid/ready and its payload. Depends on prm_pkg.
interface prm_in_if import prm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [TIME_W-1:0]   time_ms;

  modport source (output valid, output opcode, output time_ms, input ready);
  modport sink   (input valid, input opcode, input time_ms, output ready);
endinterface

interface prm_out_if import prm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COUNT_W-1:0]   pulse_count;
  logic [RATE_W-1:0]    instant_rate;
  logic [RATE_W-1:0]    one_period_rate;
  logic [RATE_W-1:0]    five_period_rate;
  logic [RATE_W-1:0]    twentyfive_period_rate;
  logic [NUM_RATES-1:0] rates_valid;

  modport source (output valid, output pulse_count, output instant_rate,
                  output one_period_rate, output five_period_rate,
                  output twentyfive_period_rate, output rates_valid,
                  input ready);
  modport sink   (input valid, input pulse_count, input instant_rate,
                  input one_period_rate, input five_period_rate,
                  input twentyfive_period_rate, input rates_valid,
                  output ready);
endinterface

// ===== rtl/pulse_rate_meter_windowed.sv =====
// Top level of the windowed pulse rate meter: sequencer, snapshot rings and
// rate cache. Depends on prm_pkg, prm_if, prm_ram and prm_div.
//
//   port     dir   width        role
//   item     in    2 + 32       opcode, time_ms (valid/ready)
//   result   out   16+4*36+4    count, four rates, rates_valid (valid/ready)
//   cfg_*    in    1 + 16       period_ms write, taken on cfg_we
//
// Pulse items and the unused opcode offer their result the cycle after they are taken.
// A sample item passes the ring look-up states S_LOOK and S_SNAP; then the instant
// rate takes the set-up state S_PREP and each ring rate S_RD_NEW, S_RD_OLD and S_PREP,
// each followed by a run of the one-bit-per-cycle divider (a zero interval skips the
// divider), and the closing state S_DONE. A restart item skips the look-up states.
// Reset is synchronous; it restores period_ms to 1000 and clears counts, rings and rates.
// A result waits in the output register; no item is taken until it leaves.
module pulse_rate_meter_windowed import prm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  prm_in_if.sink              item,
  prm_out_if.source           result
);

  logic [PERIOD_W-1:0]  period;
  logic [COUNT_W-1:0]   live_count;
  logic [COUNT_W-1:0]   sample_count;
  logic [COUNT_W-1:0]   previous_count;
  logic [TIME_W-1:0]    sample_time;
  logic [TIME_W-1:0]    previous_time;
  logic [TIME_W-1:0]    fill_time;
  pos_t                 fine_pos;
  pos_t                 coarse_pos;
  logic [RING_DEPTH-1:0] fine_valid;
  logic [RING_DEPTH-1:0] coarse_valid;
  logic                 fine_rd_ok;
  logic                 coarse_rd_ok;

  state_t               state;
  state_t               state_next;
  rate_t                rate_idx;

  pos_t                 fine_raddr;
  pos_t                 coarse_raddr;
  pos_t                 fine_waddr;
  pos_t                 coarse_waddr;
  logic                 fine_we;
  logic                 coarse_we;
  entry_t               snap_entry;
  entry_t               fine_rdata;
  entry_t               coarse_rdata;
  entry_t               fine_q;
  entry_t               coarse_q;
  entry_t               ram_q;
  entry_t               new_entry;
  entry_t               op_new;
  entry_t               op_old;

  logic [TIME_W-1:0]    fine_elapsed;
  logic [TIME_W-1:0]    coarse_elapsed;
  logic [PERIOD_W+2:0]  coarse_limit;
  logic                 fine_due;
  logic                 coarse_due;

  logic [COUNT_W-1:0]   dc;
  logic [TIME_W-1:0]    dt;
  logic                 dt_zero;
  logic [COUNT_W+SCALE_W-1:0] product;
  div_req_t             div_req;
  logic                 div_done;
  logic [RATE_W-1:0]    div_quo;

  logic [RATE_W-1:0]    rate_q [NUM_RATES];
  logic [NUM_RATES-1:0] rate_ok;
  logic                 out_valid;
  logic                 item_fire;
  logic                 result_fire;
  logic                 last_rate;
  op_t                  item_op;

  assign item_op     = op_t'(item.opcode);
  assign item_fire   = item.valid && item.ready;
  assign result_fire = out_valid && result.ready;
  assign last_rate   = (rate_idx == RATE_TWENTYFIVE);

  // ring entries never written since restart read back as a zero count at the restart time
  always_comb begin
    fine_q   = fine_rdata;
    coarse_q = coarse_rdata;
    if (!fine_rd_ok) begin
      fine_q.count = '0;
      fine_q.stamp = fill_time;
    end
    if (!coarse_rd_ok) begin
      coarse_q.count = '0;
      coarse_q.stamp = fill_time;
    end
  end

  assign ram_q = last_rate ? coarse_q : fine_q;

  assign snap_entry.count = sample_count;
  assign snap_entry.stamp = sample_time;
  assign fine_waddr       = next_pos(fine_pos);
  assign coarse_waddr     = next_pos(coarse_pos);

  assign fine_elapsed   = sample_time - fine_q.stamp;
  assign coarse_elapsed = sample_time - coarse_q.stamp;
  assign coarse_limit   = (PERIOD_W+3)'({period, 2'b00}) + (PERIOD_W+3)'(period);
  assign fine_due       = fine_elapsed > TIME_W'(period);
  assign coarse_due     = coarse_elapsed > TIME_W'(coarse_limit);

  // operands of the current rate
  always_comb begin
    if (rate_idx == RATE_INSTANT) begin
      op_new.count = sample_count;
      op_new.stamp = sample_time;
      op_old.count = previous_count;
      op_old.stamp = previous_time;
    end else begin
      op_new = new_entry;
      op_old = ram_q;
    end
  end

  assign dc      = op_new.count - op_old.count;
  assign dt      = op_new.stamp - op_old.stamp;
  assign dt_zero = (dt == '0);
  assign product = (COUNT_W+SCALE_W)'(dc) * (COUNT_W+SCALE_W)'(MILLI_SCALE);

  prm_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_fine_ram (
    .clk   (clk),
    .we    (fine_we),
    .waddr (fine_waddr),
    .wdata (snap_entry),
    .raddr (fine_raddr),
    .rdata (fine_rdata)
  );

  prm_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_coarse_ram (
    .clk   (clk),
    .we    (coarse_we),
    .waddr (coarse_waddr),
    .wdata (snap_entry),
    .raddr (coarse_raddr),
    .rdata (coarse_rdata)
  );

  prm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_fire) begin
          case (item_op)
            OP_SAMPLE:  state_next = S_LOOK;
            OP_RESTART: state_next = S_PREP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK:   state_next = S_SNAP;
      S_SNAP:   state_next = S_PREP;
      S_RD_NEW: state_next = S_RD_OLD;
      S_RD_OLD: state_next = S_PREP;
      S_PREP: begin
        if (!dt_zero) begin
          state_next = S_DIV_WAIT;
        end else begin
          state_next = last_rate ? S_DONE : S_RD_NEW;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = last_rate ? S_DONE : S_RD_NEW;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    fine_raddr       = fine_pos;
    coarse_raddr     = coarse_pos;
    fine_we          = 1'b0;
    coarse_we        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = RATE_W'(product);
    div_req.divisor  = dt;
    item.ready       = 1'b0;
    case (state)
      S_IDLE: item.ready = !rst && (!out_valid || result.ready);
      S_SNAP: begin
        fine_we   = fine_due;
        coarse_we = coarse_due;
      end
      S_RD_OLD: begin
        fine_raddr   = (rate_idx == RATE_ONE) ? prev_pos(fine_pos) : next_pos(fine_pos);
        coarse_raddr = next_pos(coarse_pos);
      end
      S_PREP:  div_req.start = !dt_zero;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rate_idx       <= RATE_INSTANT;
      live_count     <= '0;
      sample_count   <= '0;
      previous_count <= '0;
      sample_time    <= '0;
      previous_time  <= '0;
      fill_time      <= '0;
      fine_pos       <= '0;
      coarse_pos     <= '0;
      fine_valid     <= '0;
      coarse_valid   <= '0;
      fine_rd_ok     <= 1'b0;
      coarse_rd_ok   <= 1'b0;
      rate_ok        <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_RATES; i++) begin
        rate_q[i] <= '0;
      end
    end else begin
      state        <= state_next;
      fine_rd_ok   <= fine_valid[fine_raddr];
      coarse_rd_ok <= coarse_valid[coarse_raddr];
      if (result_fire && !item_fire) begin
        out_valid <= 1'b0;
      end
      if (item_fire) begin
        case (item_op)
          OP_PULSE: begin
            live_count <= live_count + 1'b1;
            out_valid  <= 1'b1;
          end
          OP_SAMPLE: begin
            previous_count <= sample_count;
            previous_time  <= sample_time;
            sample_count   <= live_count;
            sample_time    <= item.time_ms;
            rate_idx       <= RATE_INSTANT;
            out_valid      <= 1'b0;
          end
          OP_RESTART: begin
            live_count   <= '0;
            sample_count <= '0;
            sample_time  <= item.time_ms;
            fill_time    <= item.time_ms;
            fine_pos     <= '0;
            coarse_pos   <= '0;
            fine_valid   <= '0;
            coarse_valid <= '0;
            rate_idx     <= RATE_INSTANT;
            out_valid    <= 1'b0;
          end
          default: out_valid <= 1'b1;
        endcase
      end
      case (state)
        S_SNAP: begin
          if (fine_due) begin
            fine_pos               <= fine_waddr;
            fine_valid[fine_waddr] <= 1'b1;
          end
          if (coarse_due) begin
            coarse_pos                 <= coarse_waddr;
            coarse_valid[coarse_waddr] <= 1'b1;
          end
        end
        S_PREP: begin
          if (dt_zero) begin
            rate_q[rate_idx]  <= '0;
            rate_ok[rate_idx] <= 1'b0;
            rate_idx          <= rate_t'(rate_idx + 2'd1);
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            rate_q[rate_idx]  <= div_quo;
            rate_ok[rate_idx] <= 1'b1;
            rate_idx          <= rate_t'(rate_idx + 2'd1);
          end
        end
        S_DONE:  out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // hold the newest ring entry while the older one is read
  always_ff @(posedge clk) begin
    if (state == S_RD_OLD) begin
      new_entry <= ram_q;
    end
  end

  assign result.valid                  = out_valid;
  assign result.pulse_count            = live_count;
  assign result.instant_rate           = rate_q[RATE_INSTANT];
  assign result.one_period_rate        = rate_q[RATE_ONE];
  assign result.five_period_rate       = rate_q[RATE_FIVE];
  assign result.twentyfive_period_rate = rate_q[RATE_TWENTYFIVE];
  assign result.rates_valid            = rate_ok;

  a_done_reg_free: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !out_valid)
    else $error("result register still occupied when a computation ends");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished while the sequencer was not waiting");

  a_invalid_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rate_ok[0] || rate_q[0] == '0) && (rate_ok[1] || rate_q[1] == '0) &&
                   (rate_ok[2] || rate_q[2] == '0) && (rate_ok[3] || rate_q[3] == '0)))
    else $error("rate flagged invalid but not zero");

endmodule

// ===== rtl/prm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/prm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all four rates.
// Depends on prm_pkg.
module prm_div import prm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [RATE_W-1:0] quotient
);

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    quo;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [TIME_W:0]      trial;
  logic                 fits;

  assign trial    = {rem, quo[RATE_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // shift the dividend out as the quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (active) begin
      quo <= {quo[RATE_W-2:0], fits};
      rem <= fits ? TIME_W'(trial - {1'b0, dvs}) : trial[TIME_W-1:0];
    end
  end

endmodule
